/* design/dtp_pkg.sv */
`default_nettype none

package dtp_pkg;

  localparam int MaxDepth = 8;
  localparam int AddrW    = $clog2(MaxDepth);
  localparam int DepthW   = 4;
  localparam int PosW     = 32;
  localparam int MaxLenBytes = 8;
  localparam int MaxIntBytes = 8;
  localparam int QueueDepth  = 3;

  localparam logic [7:0] TagSequence = 8'h30;
  localparam logic [7:0] TagSet      = 8'h31;
  localparam logic [7:0] TagBoolean  = 8'h01;
  localparam logic [7:0] TagInteger  = 8'h02;
  localparam logic [7:0] TagBitStr   = 8'h03;
  localparam logic [7:0] TagOctStr   = 8'h04;
  localparam logic [7:0] TagNull     = 8'h05;
  localparam logic [7:0] TagOid      = 8'h06;
  localparam logic [7:0] TagUtf8     = 8'h0c;
  localparam logic [7:0] TagPrint    = 8'h13;
  localparam logic [7:0] TagUtcTime  = 8'h17;
  localparam logic [7:0] OidSplit    = 8'd40;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_LENGTH   = 3'd1;
  localparam logic [2:0] ERR_CHILD    = 3'd2;
  localparam logic [2:0] ERR_TAG      = 3'd3;
  localparam logic [2:0] ERR_OID      = 3'd4;
  localparam logic [2:0] ERR_INT_LONG = 3'd5;
  localparam logic [2:0] ERR_DEPTH    = 3'd6;
  localparam logic [2:0] ERR_BITS     = 3'd7;

  localparam logic CfgIdxSeq = 1'b0;
  localparam logic CfgIdxSet = 1'b1;

  typedef enum logic [2:0] {
    PH_TAG, PH_LEN, PH_LENX, PH_BYTES, PH_NUM, PH_OID, PH_BITS
  } phase_e;

  typedef enum logic [2:0] {
    EV_OPEN, EV_BYTE, EV_VALUE, EV_CLOSE, EV_ERROR
  } event_e;

  typedef enum logic [1:0] {
    ST_IDLE, ST_EXEC, ST_CWAIT, ST_DRAIN
  } ctl_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_word_t;

  typedef struct packed {
    event_e      event_kind;
    logic [7:0]  elem_tag;
    logic [31:0] elem_length;
    logic [3:0]  nest_depth;
    logic [63:0] payload;
    logic [2:0]  error_kind;
    logic        last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [PosW-1:0] end_pos;
    logic [7:0]      tag;
  } stk_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    stk_t             data;
  } stk_wr_t;

  typedef struct packed {
    logic             re;
    logic [AddrW-1:0] addr;
  } stk_rd_t;

  function automatic logic tag_known(logic [7:0] t);
    logic k;
    k = t[7];
    case (t)
      TagBoolean, TagInteger, TagBitStr, TagOctStr, TagNull, TagOid,
      TagUtf8, TagPrint, TagUtcTime, TagSequence, TagSet: k = 1'b1;
      default: ;
    endcase
    return k;
  endfunction

  // Quotient of a byte by forty: at most six, so a row of compares.
  function automatic logic [2:0] oid_quot(logic [7:0] b);
    logic [2:0] q;
    q = 3'd0;
    for (int k = 1; k <= 6; k++) begin
      if ({2'b00, b} >= 10'(k * 40)) q = 3'(k);
    end
    return q;
  endfunction

  function automatic out_word_t mk_event(event_e kind, logic [7:0] tag, logic [31:0] len,
                                         logic [3:0] depth, logic [63:0] pay,
                                         logic [2:0] err);
    out_word_t w;
    w.event_kind  = kind;
    w.elem_tag    = tag;
    w.elem_length = len;
    w.nest_depth  = depth;
    w.payload     = pay;
    w.error_kind  = err;
    w.last_of_run = 1'b0;
    return w;
  endfunction

endpackage

`default_nettype wire

/* design/dtp_stack_mem.sv */
`default_nettype none

module dtp_stack_mem import dtp_pkg::*; (
  input  wire logic    clk_i,
  input  wire stk_wr_t wr_i,
  input  wire stk_rd_t rd_i,
  output stk_t         rdata_o
);

  stk_t mem_q [MaxDepth];
  stk_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/der_tlv_stream_parser.sv */
`default_nettype none
// DER TLV stream parser.
// The input channel carries one word per stream byte together with a frame
// start flag; a word with frame start set clears the parser and its error
// latch before its byte is decoded. The output channel carries event words:
// element open, content byte, decoded value, element close and error.
// The last event word caused by an input byte has last_of_run set.
// An input word passes through the accept step, which reads the top of
// the nesting stack memory, a decode step, and a drain step that hands
// the events to the output register. Each close beyond the first one
// caused by the same byte adds a close check step with one stack memory
// read. A byte that causes no event passes through the same steps.
// The output register sits between the event queue and the receiver, so
// when the receiver stalls the queue holds up to three words and the input
// is stalled until the queue has drained. Bytes arriving while an error is
// latched are taken without leaving the idle state and give no events.
// Reset clears the parser state and sets the registers to parse SEQUENCE
// content and to treat SET content as bytes. Configuration is written over
// the APB port, register 0 at address 0 and register 1 at address 4.

module der_tlv_stream_parser import dtp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_word_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_word_t        out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Configuration registers.
  logic dseq_q, dset_q;

  // Control and parser state.
  ctl_e         st_q, st_d;
  phase_e       phase_q, phase_d;
  logic [7:0]   tag_q, tag_d;
  logic [31:0]  lacc_q, lacc_d;
  logic [3:0]   lbl_q, lbl_d;
  logic [3:0]   lvl_q, lvl_d;
  logic [31:0]  pos_q, pos_d;
  logic [63:0]  vacc_q, vacc_d;
  logic [3:0]   vcnt_q, vcnt_d;
  logic         oidp_q, oidp_d;
  logic         err_q, err_d;
  logic [7:0]   byte_q, byte_d;

  // Event queue ahead of the output register.
  out_word_t    evq_q [QueueDepth];
  out_word_t    evq_d [QueueDepth];
  logic [1:0]   qn_q, qn_d;
  logic         qdone_q, qdone_d;

  out_word_t    out_q;
  logic         out_valid_q;
  logic         out_free, pop;

  stk_wr_t      wr;
  stk_rd_t      rd;
  stk_t         rdata;

  dtp_stack_mem u_stack (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rdata)
  );

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {31'd0, dset_q} : {31'd0, dseq_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dseq_q <= 1'b1;
      dset_q <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == CfgIdxSeq) dseq_q <= pwdata[0];
      if (paddr[2] == CfgIdxSet) dset_q <= pwdata[0];
    end
  end

  assign in_stall_o = (st_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign pop        = out_free && (qn_q != 2'd0) && ((qn_q > 2'd1) || qdone_q);

  always_comb begin
    logic        first;
    logic        lvl0;
    logic        er;
    logic [2:0]  ek;
    logic        do_open;
    logic        push;
    logic        cmore;
    logic        last;
    logic        container;
    logic [31:0] len;
    logic [31:0] room;
    logic [31:0] la_sh;
    logic [63:0] va_n;
    logic [2:0]  quot;
    logic [1:0]  ne;
    logic [1:0]  qn_w;
    logic [3:0]  lv_eff;
    out_word_t   ev [QueueDepth];

    st_d    = st_q;
    phase_d = phase_q;
    tag_d   = tag_q;
    lacc_d  = lacc_q;
    lbl_d   = lbl_q;
    lvl_d   = lvl_q;
    pos_d   = pos_q;
    vacc_d  = vacc_q;
    vcnt_d  = vcnt_q;
    oidp_d  = oidp_q;
    err_d   = err_q;
    byte_d  = byte_q;
    qdone_d = qdone_q;
    wr      = '0;
    rd      = '0;
    first   = 1'b0;
    lvl0    = 1'b0;
    er      = 1'b0;
    ek      = ERR_NONE;
    do_open = 1'b0;
    push    = 1'b0;
    cmore   = 1'b0;
    last    = 1'b0;
    container = 1'b0;
    len     = '0;
    room    = '0;
    la_sh   = '0;
    va_n    = '0;
    quot    = '0;
    ne      = 2'd0;
    lv_eff  = lvl_q;
    for (int i = 0; i < QueueDepth; i++) ev[i] = '0;

    // Hand the head of the queue to the output register.
    evq_d = evq_q;
    qn_w  = qn_q;
    if (pop) begin
      evq_d[0] = evq_q[1];
      evq_d[1] = evq_q[2];
      qn_w     = qn_q - 2'd1;
    end
    qn_d = qn_w;

    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          byte_d  = in_data_i.data_byte;
          qdone_d = 1'b0;
          first   = err_q;
          if (in_data_i.frame_start) begin
            phase_d = PH_TAG;
            tag_d   = '0;
            lacc_d  = '0;
            lbl_d   = '0;
            lvl_d   = '0;
            pos_d   = '0;
            vacc_d  = '0;
            vcnt_d  = '0;
            oidp_d  = 1'b0;
            err_d   = 1'b0;
            first   = 1'b0;
            lv_eff  = '0;
          end
          if (!first) begin
            rd.re   = (lv_eff != 4'd0);
            rd.addr = AddrW'(lv_eff - 4'd1);
            st_d    = ST_EXEC;
          end
        end
      end

      ST_EXEC: begin
        pos_d = pos_q + 32'd1;
        case (phase_q)
          PH_TAG: begin
            tag_d = byte_q;
            if (!tag_known(byte_q)) begin
              er = 1'b1;
              ek = ERR_TAG;
            end else begin
              phase_d = PH_LEN;
            end
          end
          PH_LEN: begin
            if (!byte_q[7]) begin
              len     = {24'd0, byte_q};
              do_open = 1'b1;
            end else if (byte_q[3:0] > 4'(MaxLenBytes)) begin
              er = 1'b1;
              ek = ERR_LENGTH;
            end else if (byte_q[3:0] == 4'd0) begin
              len     = '0;
              do_open = 1'b1;
            end else begin
              lacc_d  = '0;
              lbl_d   = byte_q[3:0];
              phase_d = PH_LENX;
            end
          end
          PH_LENX: begin
            if (lacc_q[31:24] != 8'd0) begin
              er = 1'b1;
              ek = ERR_LENGTH;
            end else begin
              la_sh = {lacc_q[23:0], byte_q};
              lbl_d = lbl_q - 4'd1;
              if (lbl_q == 4'd1) begin
                len     = la_sh;
                do_open = 1'b1;
              end else begin
                lacc_d = la_sh;
              end
            end
          end
          default: begin
            lacc_d = lacc_q - 32'd1;
            last   = (lacc_q == 32'd1);
            case (phase_q)
              PH_NUM: begin
                va_n   = {vacc_q[55:0], byte_q};
                vacc_d = va_n;
                if (vcnt_q != 4'd15) vcnt_d = vcnt_q + 4'd1;
                if (last) begin
                  ev[ne] = mk_event(EV_VALUE, tag_q, '0, lvl_q, va_n, ERR_NONE);
                  ne = ne + 2'd1;
                end
              end
              PH_BITS: begin
                if (vcnt_q == 4'd0) begin
                  ev[ne] = mk_event(EV_VALUE, tag_q, '0, lvl_q, {56'd0, byte_q}, ERR_NONE);
                  vcnt_d = 4'd1;
                end else begin
                  ev[ne] = mk_event(EV_BYTE, tag_q, '0, lvl_q, {56'd0, byte_q}, ERR_NONE);
                end
                ne = ne + 2'd1;
              end
              PH_OID: begin
                if (oidp_q) begin
                  quot   = oid_quot(byte_q);
                  ev[0]  = mk_event(EV_VALUE, tag_q, '0, lvl_q, {61'd0, quot}, ERR_NONE);
                  ev[1]  = mk_event(EV_VALUE, tag_q, '0, lvl_q,
                                    {56'd0, byte_q - 8'(quot * OidSplit)}, ERR_NONE);
                  ne     = 2'd2;
                  oidp_d = 1'b0;
                end else begin
                  va_n = (vacc_q << 7) + {57'd0, byte_q[6:0]};
                  vacc_d = va_n;
                  if (byte_q[7]) begin
                    if (last) begin
                      er = 1'b1;
                      ek = ERR_OID;
                    end
                  end else begin
                    ev[ne] = mk_event(EV_VALUE, tag_q, '0, lvl_q, va_n, ERR_NONE);
                    ne     = ne + 2'd1;
                    vacc_d = '0;
                  end
                end
              end
              default: begin
                ev[ne] = mk_event(EV_BYTE, tag_q, '0, lvl_q, {56'd0, byte_q}, ERR_NONE);
                ne = ne + 2'd1;
              end
            endcase
            if (last) phase_d = PH_TAG;
          end
        endcase

        // Element header complete: check against the parent and open it.
        if (do_open) begin
          lacc_d    = len;
          room      = rdata.end_pos - pos_d;
          container = tag_d[7] || (tag_d == TagSequence && dseq_q) ||
                      (tag_d == TagSet && dset_q);
          if (lvl_q != 4'd0 && len > room) begin
            er = 1'b1;
            ek = ERR_CHILD;
          end else if (container) begin
            if (lvl_q >= 4'(MaxDepth)) begin
              er = 1'b1;
              ek = ERR_DEPTH;
            end else begin
              ev[ne]  = mk_event(EV_OPEN, tag_d, len, lvl_q, '0, ERR_NONE);
              ne      = ne + 2'd1;
              push    = 1'b1;
              lvl_d   = lvl_q + 4'd1;
              phase_d = PH_TAG;
            end
          end else begin
            vacc_d = '0;
            vcnt_d = '0;
            if (tag_d == TagBoolean || tag_d == TagInteger) begin
              if (len > 32'(MaxIntBytes)) begin
                er = 1'b1;
                ek = ERR_INT_LONG;
              end else begin
                ev[ne] = mk_event(EV_OPEN, tag_d, len, lvl_q, '0, ERR_NONE);
                ne = ne + 2'd1;
                if (len == 32'd0) begin
                  ev[ne]  = mk_event(EV_VALUE, tag_d, '0, lvl_q, '0, ERR_NONE);
                  ne      = ne + 2'd1;
                  phase_d = PH_TAG;
                end else begin
                  phase_d = PH_NUM;
                end
              end
            end else if (tag_d == TagBitStr) begin
              if (len == 32'd0) begin
                er = 1'b1;
                ek = ERR_BITS;
              end else begin
                ev[ne]  = mk_event(EV_OPEN, tag_d, len, lvl_q, '0, ERR_NONE);
                ne      = ne + 2'd1;
                phase_d = PH_BITS;
              end
            end else if (tag_d == TagOid) begin
              if (len == 32'd0) begin
                er = 1'b1;
                ek = ERR_OID;
              end else begin
                ev[ne]  = mk_event(EV_OPEN, tag_d, len, lvl_q, '0, ERR_NONE);
                ne      = ne + 2'd1;
                oidp_d  = 1'b1;
                phase_d = PH_OID;
              end
            end else begin
              ev[ne]  = mk_event(EV_OPEN, tag_d, len, lvl_q, '0, ERR_NONE);
              ne      = ne + 2'd1;
              phase_d = (len != 32'd0) ? PH_BYTES : PH_TAG;
            end
          end
        end

        wr.we        = push;
        wr.addr      = lvl_q[AddrW-1:0];
        wr.data      = '{end_pos: pos_d + len, tag: tag_d};

        // A header that runs into the parent end is an error; after a
        // finished element the innermost container may close.
        if (!er) begin
          if (phase_d == PH_LEN || phase_d == PH_LENX) begin
            if (lvl_q != 4'd0 && rdata.end_pos == pos_d) begin
              er = 1'b1;
              ek = ERR_CHILD;
            end
          end else if (phase_d == PH_TAG) begin
            if (push) begin
              lvl0 = (len == 32'd0);
              if (lvl0) begin
                ev[ne] = mk_event(EV_CLOSE, tag_d, '0, lvl_q, '0, ERR_NONE);
                ne     = ne + 2'd1;
                lvl_d  = lvl_q;
                cmore  = (lvl_q != 4'd0);
              end
            end else if (lvl_q != 4'd0 && rdata.end_pos == pos_d) begin
              ev[ne] = mk_event(EV_CLOSE, rdata.tag, '0, lvl_q - 4'd1, '0, ERR_NONE);
              ne     = ne + 2'd1;
              lvl_d  = lvl_q - 4'd1;
              cmore  = (lvl_q != 4'd1);
            end
          end
        end
        if (er) begin
          ev[ne] = mk_event(EV_ERROR, tag_d, '0, lvl_q, '0, ek);
          ne     = ne + 2'd1;
          cmore  = 1'b0;
        end
        err_d = er;

        evq_d = ev;
        qn_d  = ne;
        if (cmore) begin
          rd.re   = 1'b1;
          rd.addr = AddrW'(lvl_d - 4'd1);
          st_d    = ST_CWAIT;
        end else begin
          qdone_d = 1'b1;
          st_d    = ST_DRAIN;
        end
      end

      ST_CWAIT: begin
        if (qn_w != 2'(QueueDepth)) begin
          if (rdata.end_pos == pos_q) begin
            evq_d[qn_w] = mk_event(EV_CLOSE, rdata.tag, '0, lvl_q - 4'd1, '0, ERR_NONE);
            qn_d        = qn_w + 2'd1;
            lvl_d       = lvl_q - 4'd1;
            if (lvl_q != 4'd1) begin
              rd.re   = 1'b1;
              rd.addr = AddrW'(lvl_q - 4'd2);
            end else begin
              qdone_d = 1'b1;
              st_d    = ST_DRAIN;
            end
          end else begin
            qdone_d = 1'b1;
            st_d    = ST_DRAIN;
          end
        end
      end

      ST_DRAIN: begin
        if (qn_w == 2'd0) st_d = ST_IDLE;
      end

      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      phase_q <= PH_TAG;
      tag_q   <= '0;
      lacc_q  <= '0;
      lbl_q   <= '0;
      lvl_q   <= '0;
      pos_q   <= '0;
      vacc_q  <= '0;
      vcnt_q  <= '0;
      oidp_q  <= 1'b0;
      err_q   <= 1'b0;
      qn_q    <= '0;
      qdone_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      phase_q <= phase_d;
      tag_q   <= tag_d;
      lacc_q  <= lacc_d;
      lbl_q   <= lbl_d;
      lvl_q   <= lvl_d;
      pos_q   <= pos_d;
      vacc_q  <= vacc_d;
      vcnt_q  <= vcnt_d;
      oidp_q  <= oidp_d;
      err_q   <= err_d;
      qn_q    <= qn_d;
      qdone_q <= qdone_d;
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    evq_q  <= evq_d;
    if (pop) begin
      out_q             <= evq_q[0];
      out_q.last_of_run <= (qn_q == 2'd1) && qdone_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_accept_queue_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> (qn_q == 2'd0))
    else $error("input accepted while events are queued");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.we |-> (lvl_q < 4'(MaxDepth)))
    else $error("stack push beyond maximum depth");

  a_exec_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_EXEC) |-> $past(in_valid_i && !in_stall_o))
    else $error("decode cycle without an accepted byte");

  a_cwait_nonzero_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CWAIT) |-> (lvl_q != 4'd0))
    else $error("close check with an empty stack");

endmodule

`default_nettype wire
